// ----- rtl/core/ite_pkg.sv -----
package ite_pkg;

   // depth of the queue between parser and converter
   localparam int unsigned ITE_QUEUE_DEPTH = 2;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned SMALL_W = 7;
   localparam int unsigned EPOCH_W = 39;

   // parsed fields of one timestamp, handed from parser to converter
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [SMALL_W-1:0] month;
      logic [SMALL_W-1:0] day;
      logic [SMALL_W-1:0] hour;
      logic [SMALL_W-1:0] minute;
      logic [SMALL_W-1:0] second;
      logic               offset_negative;
      logic [SMALL_W-1:0] offset_hours;
      logic [SMALL_W-1:0] offset_minutes;
   } ite_entry_type;

   typedef enum logic [1:0] {
      PH_DATETIME,
      PH_FRACTION,
      PH_OFF_HOURS,
      PH_OFF_MINUTES
   } ite_phase_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DAYS,
      BK_LEAP4,
      BK_LEAP100,
      BK_LEAP400,
      BK_HOURS,
      BK_MINUTES,
      BK_SECONDS,
      BK_FINISH
   } ite_back_state_type;

   localparam logic [15:0] EPOCH_YEAR    = 16'd1970;
   localparam logic [15:0] LEAP4_BASE    = 16'd1968;
   localparam logic [15:0] LEAP100_BASE  = 16'd1900;
   localparam logic [15:0] LEAP400_BASE  = 16'd1600;
   localparam logic [18:0] SEC_PER_HOUR  = 19'd3600;
   localparam logic [18:0] SEC_PER_MIN   = 19'd60;
   // reciprocal of 100, scaled by 2**21, exact for operands below 43690
   localparam logic [14:0] RECIP_100     = 15'd20972;
   localparam int unsigned RECIP_SHIFT   = 21;
   // reciprocal of 12, scaled by 2**11, exact for month values below 128
   localparam logic [7:0]  RECIP_12      = 8'd171;

   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [YEAR_W-1:0] push_year(input logic [YEAR_W-1:0] acc,
                                                   input logic [3:0] d);
      logic [YEAR_W+3:0] v;
      v = (YEAR_W+4)'(acc) * (YEAR_W+4)'(10) + (YEAR_W+4)'(d);
      return (v > (YEAR_W+4)'({YEAR_W{1'b1}})) ? {YEAR_W{1'b1}} : v[YEAR_W-1:0];
   endfunction

   function automatic logic [SMALL_W-1:0] push_small(input logic [SMALL_W-1:0] acc,
                                                     input logic [3:0] d);
      logic [SMALL_W+3:0] v;
      v = (SMALL_W+4)'(acc) * (SMALL_W+4)'(10) + (SMALL_W+4)'(d);
      return (v > (SMALL_W+4)'({SMALL_W{1'b1}})) ? {SMALL_W{1'b1}} : v[SMALL_W-1:0];
   endfunction

endpackage

// ----- rtl/core/ite_front.sv -----
module ite_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_code,
   input  logic                  req_last_char,
   input  logic                  queue_full,
   output logic                  push_valid,
   output ite_pkg::ite_entry_type push_entry
);
   import ite_pkg::*;

   localparam logic [2:0] FI_YEAR   = 3'd0;
   localparam logic [2:0] FI_MONTH  = 3'd1;
   localparam logic [2:0] FI_DAY    = 3'd2;
   localparam logic [2:0] FI_HOUR   = 3'd3;
   localparam logic [2:0] FI_MINUTE = 3'd4;
   localparam logic [2:0] FI_SECOND = 3'd5;
   localparam logic [2:0] FI_DONE   = 3'd6;
   localparam logic [2:0] FI_ZULU   = 3'd7;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   ite_entry_type fields_ff, fields_in;
   logic [2:0]    field_ff, field_in;
   ite_phase_type phase_ff, phase_in;
   logic          seen_t_ff, seen_t_in;

   logic          is_digit;
   logic [7:0]    digit_full;
   logic [3:0]    digit;
   logic [2:0]    field_step;
   logic          take;

   assign req_ready  = !queue_full;
   assign take       = req_valid && req_ready;
   assign push_valid = take && req_last_char;
   assign push_entry = fields_in;

   assign is_digit   = (req_char_code >= CH_ZERO) && (req_char_code <= CH_NINE);
   assign digit_full = req_char_code - CH_ZERO;
   assign digit      = is_digit ? digit_full[3:0] : 4'd0;
   assign field_step = (field_ff < FI_DONE) ? field_ff + 3'd1 : field_ff;

   always_comb begin
      fields_in = fields_ff;
      field_in  = field_ff;
      phase_in  = phase_ff;
      seen_t_in = seen_t_ff;
      if (field_ff != FI_ZULU) begin
         if (req_char_code == CH_Z) begin
            // zulu clears any offset and freezes the parser
            field_in                 = FI_ZULU;
            phase_in                 = PH_FRACTION;
            fields_in.offset_negative = 1'b0;
            fields_in.offset_hours    = '0;
            fields_in.offset_minutes  = '0;
         end else begin
            case (phase_ff)
               PH_DATETIME: begin
                  if (is_digit) begin
                     case (field_ff)
                        FI_YEAR:   fields_in.year   = push_year(fields_ff.year, digit);
                        FI_MONTH:  fields_in.month  = push_small(fields_ff.month, digit);
                        FI_DAY:    fields_in.day    = push_small(fields_ff.day, digit);
                        FI_HOUR:   fields_in.hour   = push_small(fields_ff.hour, digit);
                        FI_MINUTE: fields_in.minute = push_small(fields_ff.minute, digit);
                        FI_SECOND: fields_in.second = push_small(fields_ff.second, digit);
                        default: ;
                     endcase
                  end else if (req_char_code == CH_T) begin
                     seen_t_in = 1'b1;
                     field_in  = field_step;
                  end else if (req_char_code == CH_COLON) begin
                     field_in = field_step;
                  end else if (req_char_code == CH_MINUS) begin
                     // a minus before the time part is a date separator
                     if (seen_t_ff) begin
                        fields_in.offset_negative = 1'b1;
                        phase_in                  = PH_OFF_HOURS;
                     end else begin
                        field_in = field_step;
                     end
                  end else if (req_char_code == CH_PLUS) begin
                     fields_in.offset_negative = 1'b0;
                     phase_in                  = PH_OFF_HOURS;
                  end else if (req_char_code == CH_DOT) begin
                     phase_in = PH_FRACTION;
                  end
               end
               PH_FRACTION: begin
                  if (req_char_code == CH_PLUS) begin
                     fields_in.offset_negative = 1'b0;
                     phase_in                  = PH_OFF_HOURS;
                  end else if (req_char_code == CH_MINUS && seen_t_ff) begin
                     fields_in.offset_negative = 1'b1;
                     phase_in                  = PH_OFF_HOURS;
                  end
               end
               PH_OFF_HOURS: begin
                  if (is_digit) begin
                     fields_in.offset_hours = push_small(fields_ff.offset_hours, digit);
                  end else if (req_char_code == CH_COLON) begin
                     phase_in = PH_OFF_MINUTES;
                  end
               end
               PH_OFF_MINUTES: begin
                  if (is_digit) begin
                     fields_in.offset_minutes = push_small(fields_ff.offset_minutes, digit);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && req_last_char)) begin
         fields_ff <= '0;
         field_ff  <= FI_YEAR;
         phase_ff  <= PH_DATETIME;
         seen_t_ff <= 1'b0;
      end else if (take) begin
         fields_ff <= fields_in;
         field_ff  <= field_in;
         phase_ff  <= phase_in;
         seen_t_ff <= seen_t_in;
      end
   end

endmodule

// ----- rtl/core/ite_queue.sv -----
module ite_queue #(
   parameter int unsigned DEPTH = ite_pkg::ITE_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  ite_pkg::ite_entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output ite_pkg::ite_entry_type head
);
   import ite_pkg::*;

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ite_entry_type    entries_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/core/ite_back.sv -----
module ite_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   output logic                  pop,
   input  ite_pkg::ite_entry_type head,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ite_pkg::EPOCH_W-1:0] rsp_epoch_seconds
);
   import ite_pkg::*;

   ite_back_state_type state_ff, state_in;
   logic               rsp_load;

   // datapath registers, two's complement modulo their width
   logic [15:0]        year_ff, y2_ff;
   logic [3:0]         mon_ff;
   logic [SMALL_W-1:0] day_ff, hour_ff, minute_ff, second_ff;
   logic [SMALL_W-1:0] offh_ff, offm_ff;
   logic               neg_ff;
   logic [18:0]        off_ff;
   logic [EPOCH_W-1:0] r_ff;
   logic [7:0]         q100_ff;
   logic               b_neg_ff;
   logic [11:0]        c4_ff;
   logic               c_neg_ff;
   logic [5:0]         q400_ff;
   logic               rsp_valid_ff;
   logic [EPOCH_W-1:0] rsp_data_ff;

   // load: month normalization
   logic        month_zero;
   logic [6:0]  mon0;
   logic [14:0] mon_prod;
   logic [3:0]  mon_q;
   logic [6:0]  mon_rem;
   logic [3:0]  mon_load;
   logic [15:0] year_load;

   // days
   logic [15:0]        y_rel;
   logic [EPOCH_W-1:0] r_days;
   logic [15:0]        y2_calc;
   logic [18:0]        off_calc;

   // leap corrections
   logic [15:0]        a_rel, a_mag, b_rel, b_mag, c_rel, c_mag;
   logic [EPOCH_W-1:0] leap4;
   logic [29:0]        b_prod;
   logic [26:0]        c_prod;
   logic [EPOCH_W-1:0] q100_ext, q400_ext;

   logic [EPOCH_W-1:0] r_final;

   always_comb begin
      month_zero = (head.month == '0);
      mon0       = head.month - 7'd1;
      mon_prod   = 15'(mon0) * 15'(RECIP_12);
      mon_q      = mon_prod[14:11];
      mon_rem    = mon0 - (7'({mon_q, 3'b000}) + 7'({mon_q, 2'b00}));
      // month zero borrows a year
      mon_load   = month_zero ? 4'd11 : mon_rem[3:0];
      year_load  = month_zero ? 16'(head.year) - 16'd1 : 16'(head.year) + 16'(mon_q);
   end

   always_comb begin
      y_rel    = year_ff - EPOCH_YEAR;
      r_days   = {{(EPOCH_W-16){y_rel[15]}}, y_rel} * EPOCH_W'(365)
               + EPOCH_W'(days_before_month(mon_ff));
      // january and february count the leap day of the year before
      y2_calc  = year_ff - ((mon_ff <= 4'd1) ? 16'd1 : 16'd0);
      off_calc = 19'(offh_ff) * SEC_PER_HOUR + 19'(offm_ff) * SEC_PER_MIN;
   end

   always_comb begin
      a_rel  = y2_ff - LEAP4_BASE;
      a_mag  = a_rel[15] ? -a_rel : a_rel;
      leap4  = EPOCH_W'(a_mag[15:2]);
      if (a_rel[15]) begin
         leap4 = -leap4;
      end
      b_rel  = y2_ff - LEAP100_BASE;
      b_mag  = b_rel[15] ? -b_rel : b_rel;
      b_prod = 30'(b_mag[14:0]) * 30'(RECIP_100);
      c_rel  = y2_ff - LEAP400_BASE;
      c_mag  = c_rel[15] ? -c_rel : c_rel;
      // truncating divide by 400 as divide by 4 then by 100
      c_prod = 27'(c4_ff) * 27'(RECIP_100);
      q100_ext = b_neg_ff ? -EPOCH_W'(q100_ff) : EPOCH_W'(q100_ff);
      q400_ext = c_neg_ff ? -EPOCH_W'(q400_ff) : EPOCH_W'(q400_ff);
      r_final  = neg_ff ? r_ff + EPOCH_W'(off_ff) : r_ff - EPOCH_W'(off_ff);
   end

   // outputs of the sequencer
   always_comb begin
      pop      = (state_ff == BK_IDLE) && !queue_empty;
      rsp_load = (state_ff == BK_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:    if (!queue_empty) state_in = BK_DAYS;
         BK_DAYS:    state_in = BK_LEAP4;
         BK_LEAP4:   state_in = BK_LEAP100;
         BK_LEAP100: state_in = BK_LEAP400;
         BK_LEAP400: state_in = BK_HOURS;
         BK_HOURS:   state_in = BK_MINUTES;
         BK_MINUTES: state_in = BK_SECONDS;
         BK_SECONDS: state_in = BK_FINISH;
         BK_FINISH:  if (rsp_load) state_in = BK_IDLE;
         default:    state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            year_ff   <= year_load;
            mon_ff    <= mon_load;
            day_ff    <= head.day;
            hour_ff   <= head.hour;
            minute_ff <= head.minute;
            second_ff <= head.second;
            neg_ff    <= head.offset_negative;
            offh_ff   <= head.offset_hours;
            offm_ff   <= head.offset_minutes;
         end
         BK_DAYS: begin
            r_ff   <= r_days;
            y2_ff  <= y2_calc;
            off_ff <= off_calc;
         end
         BK_LEAP4: begin
            r_ff     <= r_ff + leap4;
            q100_ff  <= b_prod[RECIP_SHIFT+7:RECIP_SHIFT];
            b_neg_ff <= b_rel[15];
            c4_ff    <= c_mag[13:2];
            c_neg_ff <= c_rel[15];
         end
         BK_LEAP100: begin
            r_ff    <= r_ff - q100_ext;
            q400_ff <= c_prod[RECIP_SHIFT+5:RECIP_SHIFT];
         end
         BK_LEAP400: r_ff <= r_ff + q400_ext + EPOCH_W'(day_ff) - EPOCH_W'(1);
         BK_HOURS:   r_ff <= r_ff * EPOCH_W'(24) + EPOCH_W'(hour_ff);
         BK_MINUTES: r_ff <= r_ff * EPOCH_W'(60) + EPOCH_W'(minute_ff);
         BK_SECONDS: r_ff <= r_ff * EPOCH_W'(60) + EPOCH_W'(second_ff);
         BK_FINISH:  if (rsp_load) rsp_data_ff <= r_final;
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = rsp_data_ff;

endmodule

// ----- rtl/core/iso_timestamp_to_epoch_top.sv -----
// throughput: one character per cycle while the queue has room; strings are converted
// one at a time by the nine-step date converter behind the parser queue
// reset: synchronous, active high; clears parser state, queue pointers,
// converter sequencer and the result valid flag
module iso_timestamp_to_epoch_top #(
   parameter int unsigned QUEUE_DEPTH = ite_pkg::ITE_QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   // character channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_last_char,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ite_pkg::EPOCH_W-1:0]  rsp_epoch_seconds
);
   import ite_pkg::*;

   // parser to queue
   logic          push_valid;
   ite_entry_type push_entry;
   logic          queue_full;

   // queue to converter
   logic          queue_empty;
   logic          pop;
   ite_entry_type head;

   // front: walks the string a character a transfer and gathers the
   // date, time and zone fields; the last character pushes a snapshot
   ite_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_entry    (push_entry)
   );

   // short queue so the parser keeps taking characters while a
   // conversion runs or a result waits on rsp_ready
   ite_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   // back: month fold, day count, leap corrections, then
   // hours, minutes, seconds and zone offset, one step a cycle; the last step waits while an earlier result is held
   ite_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .pop               (pop),
      .head              (head),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

endmodule

// ----- rtl/core/ite_checker.sv -----
module ite_checker #(
   parameter int unsigned QUEUE_DEPTH = ite_pkg::ITE_QUEUE_DEPTH
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last_char,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ite_pkg::EPOCH_W-1:0] rsp_epoch_seconds
);
   import ite_pkg::*;

   localparam int unsigned PEND_W = $clog2(QUEUE_DEPTH + 3);

   // strings whose last character was taken but whose result is not yet out
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic              str_in, str_out;

   assign str_in  = req_valid && req_ready && req_last_char;
   assign str_out = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (str_in && !str_out) begin
         pending_in = pending_ff + 1'b1;
      end else if (str_out && !str_in) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_epoch_seconds))
      else $error("stalled result changed");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without a finished string");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> pending_ff >= PEND_W'(QUEUE_DEPTH))
      else $error("input stalled with room in the queue");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PEND_W'(QUEUE_DEPTH + 2))
      else $error("more strings in flight than storage");

endmodule

bind iso_timestamp_to_epoch_top ite_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);
